### sv/id3w_pkg.sv
// Shared types and constants for the ID3v2 tag frame walker.
package id3w_pkg;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_FHDR    = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_DONE    = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_HDR_BYTE  = 3'd0,
    EV_TAG_HDR   = 3'd1,
    EV_FRAME_HDR = 3'd2,
    EV_PAYLOAD   = 3'd3,
    EV_TAG_END   = 3'd4,
    EV_BAD_MAGIC = 3'd5,
    EV_OUTSIDE   = 3'd6
  } event_t;

  localparam logic [7:0] MAGIC0 = 8'h49;  // 'I'
  localparam logic [7:0] MAGIC1 = 8'h44;  // 'D'
  localparam logic [7:0] MAGIC2 = 8'h33;  // '3'

  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_W = 8'h57;

  localparam logic [31:0] ID_TXXX = 32'h54585858;
  localparam logic [31:0] ID_WXXX = 32'h57585858;
  localparam logic [31:0] ID_ETCO = 32'h4554434F;
  localparam logic [31:0] ID_RBUF = 32'h52425546;
  localparam logic [31:0] ID_USER = 32'h55534552;
  localparam logic [31:0] ID_SYLT = 32'h53594C54;
  localparam logic [31:0] ID_SEEK = 32'h5345454B;
  localparam logic [31:0] ID_UFID = 32'h55464944;
  localparam logic [31:0] ID_PRIV = 32'h50524956;
  localparam logic [31:0] ID_ENCR = 32'h454E4352;
  localparam logic [31:0] ID_GRID = 32'h47524944;
  localparam logic [31:0] ID_OWNE = 32'h4F574E45;
  localparam logic [31:0] ID_USLT = 32'h55534C54;
  localparam logic [31:0] ID_COMM = 32'h434F4D4D;
  localparam logic [31:0] ID_LINK = 32'h4C494E4B;
  localparam logic [31:0] ID_COMR = 32'h434F4D52;
  localparam logic [31:0] ID_EQU2 = 32'h45515532;
  localparam logic [31:0] ID_RVRB = 32'h52565242;
  localparam logic [31:0] ID_PCNT = 32'h50434E54;
  localparam logic [31:0] ID_POPM = 32'h504F504D;
  localparam logic [31:0] ID_POSS = 32'h504F5353;
  localparam logic [31:0] ID_RVA2 = 32'h52564132;

  localparam logic [4:0] KIND_UNKNOWN = 5'd0;
  localparam logic [4:0] KIND_TEXT    = 5'd1;
  localparam logic [4:0] KIND_URL     = 5'd2;
  localparam logic [4:0] KIND_USERDEF = 5'd3;
  localparam logic [4:0] KIND_ETCO    = 5'd4;
  localparam logic [4:0] KIND_RBUF    = 5'd5;
  localparam logic [4:0] KIND_USER    = 5'd6;
  localparam logic [4:0] KIND_SYLT    = 5'd7;
  localparam logic [4:0] KIND_SEEK    = 5'd8;
  localparam logic [4:0] KIND_OWNERID = 5'd9;
  localparam logic [4:0] KIND_REGID   = 5'd10;
  localparam logic [4:0] KIND_OWNE    = 5'd11;
  localparam logic [4:0] KIND_LANGTXT = 5'd12;
  localparam logic [4:0] KIND_LINK    = 5'd13;
  localparam logic [4:0] KIND_COMR    = 5'd14;
  localparam logic [4:0] KIND_EQU2    = 5'd15;
  localparam logic [4:0] KIND_RVRB    = 5'd16;
  localparam logic [4:0] KIND_PCNT    = 5'd17;
  localparam logic [4:0] KIND_POPM    = 5'd18;
  localparam logic [4:0] KIND_POSS    = 5'd19;
  localparam logic [4:0] KIND_RVA2    = 5'd20;

  localparam logic [3:0] HDR_LAST_IDX = 4'd9;
  localparam logic [31:0] FRAME_HDR_LEN = 32'd10;

endpackage

### sv/id3w_kind_class.sv
// Frame id classifier: maps a four-character frame id to its frame kind.
module id3w_kind_class (
  input  logic [31:0] id_word,
  output logic [4:0]  frame_kind
);

  always_comb begin
    unique case (id_word)
      id3w_pkg::ID_POSS: frame_kind = id3w_pkg::KIND_POSS;
      id3w_pkg::ID_RVA2: frame_kind = id3w_pkg::KIND_RVA2;
      id3w_pkg::ID_TXXX,
      id3w_pkg::ID_WXXX: frame_kind = id3w_pkg::KIND_USERDEF;
      id3w_pkg::ID_ETCO: frame_kind = id3w_pkg::KIND_ETCO;
      id3w_pkg::ID_RBUF: frame_kind = id3w_pkg::KIND_RBUF;
      id3w_pkg::ID_USER: frame_kind = id3w_pkg::KIND_USER;
      id3w_pkg::ID_SYLT: frame_kind = id3w_pkg::KIND_SYLT;
      id3w_pkg::ID_SEEK: frame_kind = id3w_pkg::KIND_SEEK;
      id3w_pkg::ID_UFID,
      id3w_pkg::ID_PRIV: frame_kind = id3w_pkg::KIND_OWNERID;
      id3w_pkg::ID_ENCR,
      id3w_pkg::ID_GRID: frame_kind = id3w_pkg::KIND_REGID;
      id3w_pkg::ID_OWNE: frame_kind = id3w_pkg::KIND_OWNE;
      id3w_pkg::ID_USLT,
      id3w_pkg::ID_COMM: frame_kind = id3w_pkg::KIND_LANGTXT;
      id3w_pkg::ID_LINK: frame_kind = id3w_pkg::KIND_LINK;
      id3w_pkg::ID_COMR: frame_kind = id3w_pkg::KIND_COMR;
      id3w_pkg::ID_EQU2: frame_kind = id3w_pkg::KIND_EQU2;
      id3w_pkg::ID_RVRB: frame_kind = id3w_pkg::KIND_RVRB;
      id3w_pkg::ID_PCNT: frame_kind = id3w_pkg::KIND_PCNT;
      id3w_pkg::ID_POPM: frame_kind = id3w_pkg::KIND_POPM;
      default: begin
        // fall back on the first character: text and url families
        if (id_word[31:24] == id3w_pkg::CHAR_T) begin
          frame_kind = id3w_pkg::KIND_TEXT;
        end else if (id_word[31:24] == id3w_pkg::CHAR_W) begin
          frame_kind = id3w_pkg::KIND_URL;
        end else begin
          frame_kind = id3w_pkg::KIND_UNKNOWN;
        end
      end
    endcase
  end

endmodule

### sv/id3v2_tag_frame_walker_core.sv
// Top level of the ID3v2 tag frame walker: byte parser with a registered result stage.
//
// Usage:
//   Input stream (s_*): one file byte per transfer in s_tdata[7:0]; s_tuser
//   high marks the first byte of a new file and restarts the parser.
//   Output stream (m_*): exactly one result per input byte. m_tuser carries
//   the event code (header byte, tag header done, frame header done,
//   payload byte, tag end, bad magic, byte outside tag). m_tdata carries the
//   tag header values and the current frame header values plus the payload
//   byte; m_tlast marks the final payload byte of a frame.
//   Output timing: the result of a byte appears in the cycle after its transfer.
//   Throughput: one byte per cycle while results are claimed; each byte is
//   parsed by a few compares and one 32-bit count update between the parser
//   state and the result register.
//   Stall: s_tready follows the result register; while a result waits
//   unclaimed, the input side stalls, otherwise a new byte enters each cycle.
//   Reset (rst, synchronous): drop any pending result and return the parser
//   to the tag header phase with all held values cleared. Bytes arriving
//   without a start mark after reset are parsed as a tag header.
module id3v2_tag_frame_walker_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] start_of_file
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // [7:0] version, [15:8] revision, [19:16] tag_flags,
                                  // [47:20] tag_len, [79:48] id_word,
                                  // [84:80] frame_kind, [112:85] frame_len,
                                  // [128:113] frame_flags, [136:129] payload_byte,
                                  // [143:137] zero
  output logic [2:0]   m_tuser,   // [2:0] event_res
  output logic         m_tlast    // last_of_frame
);

  // Parser state
  id3w_pkg::phase_t phase, phase_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [31:0] header_shift, header_shift_next;
  logic [27:0] tag_size_reg, tag_size_reg_next;
  logic [31:0] consumed_count, consumed_count_next;
  logic [31:0] frame_id_reg, frame_id_reg_next;
  logic [27:0] frame_size_reg, frame_size_reg_next;
  logic [27:0] payload_left, payload_left_next;
  logic [15:0] frame_flags_reg, frame_flags_reg_next;
  logic [7:0]  version_reg, version_reg_next;
  logic [7:0]  revision_reg, revision_reg_next;
  logic [3:0]  tag_flags_reg, tag_flags_reg_next;

  // State as seen by the current byte (a start mark clears it first)
  id3w_pkg::phase_t cur_phase;
  logic [3:0]  cur_index;
  logic [31:0] cur_shift;
  logic [27:0] cur_tag_size;
  logic [31:0] cur_consumed;
  logic [31:0] cur_frame_id;
  logic [27:0] cur_frame_len;
  logic [27:0] cur_left;
  logic [15:0] cur_frame_flags;
  logic [7:0]  cur_version;
  logic [7:0]  cur_revision;
  logic [3:0]  cur_tag_flags;

  logic        s_accept;
  logic [7:0]  b;
  logic        magic_bad;
  logic        hdr_last;
  logic        tag_over;
  logic [7:0]  magic_ref;
  logic [27:0] left_dec;

  id3w_pkg::event_t ev;
  logic [7:0]  pbyte;
  logic        last;
  logic [4:0]  kind_next;

  // Result register
  id3w_pkg::event_t out_ev;
  logic [7:0]  out_version;
  logic [7:0]  out_revision;
  logic [3:0]  out_tag_flags;
  logic [27:0] out_tag_size;
  logic [31:0] out_frame_id;
  logic [4:0]  out_frame_kind;
  logic [27:0] out_frame_size;
  logic [15:0] out_frame_flags;
  logic [7:0]  out_payload;
  logic        out_last;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign b        = s_tdata;

  // Apply the start mark: the byte then sees reset state
  always_comb begin
    if (s_tuser) begin
      cur_phase       = id3w_pkg::PH_TAG;
      cur_index       = '0;
      cur_shift       = '0;
      cur_tag_size    = '0;
      cur_consumed    = '0;
      cur_frame_id    = '0;
      cur_frame_len   = '0;
      cur_left        = '0;
      cur_frame_flags = '0;
      cur_version     = '0;
      cur_revision    = '0;
      cur_tag_flags   = '0;
    end else begin
      cur_phase       = phase;
      cur_index       = byte_index;
      cur_shift       = header_shift;
      cur_tag_size    = tag_size_reg;
      cur_consumed    = consumed_count;
      cur_frame_id    = frame_id_reg;
      cur_frame_len   = frame_size_reg;
      cur_left        = payload_left;
      cur_frame_flags = frame_flags_reg;
      cur_version     = version_reg;
      cur_revision    = revision_reg;
      cur_tag_flags   = tag_flags_reg;
    end
  end

  // Shared decode terms
  always_comb begin
    case (cur_index[1:0])
      2'd0:    magic_ref = id3w_pkg::MAGIC0;
      2'd1:    magic_ref = id3w_pkg::MAGIC1;
      default: magic_ref = id3w_pkg::MAGIC2;
    endcase
  end

  assign magic_bad = (cur_index < 4'd3) && (b != magic_ref);
  assign hdr_last  = (cur_index >= id3w_pkg::HDR_LAST_IDX);
  // Tag ends where a frame header would start: size reached or padding
  assign tag_over  = (cur_index == 4'd0) &&
                     ((cur_consumed >= {4'd0, cur_tag_size}) || (b == 8'd0));
  assign left_dec  = (cur_left != 28'd0) ? cur_left - 28'd1 : 28'd0;

  // Next state
  always_comb begin
    phase_next           = cur_phase;
    byte_index_next      = cur_index;
    header_shift_next    = cur_shift;
    tag_size_reg_next    = cur_tag_size;
    consumed_count_next  = cur_consumed;
    frame_id_reg_next    = cur_frame_id;
    frame_size_reg_next  = cur_frame_len;
    payload_left_next    = cur_left;
    frame_flags_reg_next = cur_frame_flags;
    version_reg_next     = cur_version;
    revision_reg_next    = cur_revision;
    tag_flags_reg_next   = cur_tag_flags;
    unique case (cur_phase)
      id3w_pkg::PH_TAG: begin
        if (magic_bad) begin
          phase_next = id3w_pkg::PH_ERROR;
        end else begin
          if (cur_index == 4'd3) begin
            version_reg_next = b;
          end else if (cur_index == 4'd4) begin
            revision_reg_next = b;
          end else if (cur_index == 4'd5) begin
            tag_flags_reg_next = b[7:4];
          end else if (cur_index > 4'd5) begin
            // syncsafe: seven bits per byte
            header_shift_next = {4'd0, cur_shift[20:0], b[6:0]};
          end
          if (hdr_last) begin
            tag_size_reg_next   = header_shift_next[27:0];
            header_shift_next   = '0;
            byte_index_next     = '0;
            consumed_count_next = '0;
            phase_next          = id3w_pkg::PH_FHDR;
          end else begin
            byte_index_next = cur_index + 4'd1;
          end
        end
      end
      id3w_pkg::PH_FHDR: begin
        if (tag_over) begin
          phase_next = id3w_pkg::PH_DONE;
        end else begin
          if (cur_index < 4'd4) begin
            header_shift_next = {cur_shift[23:0], b};
            if (cur_index == 4'd3) begin
              frame_id_reg_next = header_shift_next;
              header_shift_next = '0;
            end
          end else if (cur_index < 4'd8) begin
            header_shift_next = {4'd0, cur_shift[20:0], b[6:0]};
            if (cur_index == 4'd7) begin
              frame_size_reg_next = header_shift_next[27:0];
              header_shift_next   = '0;
            end
          end else begin
            header_shift_next = {16'd0, cur_shift[7:0], b};
          end
          if (hdr_last) begin
            frame_flags_reg_next = header_shift_next[15:0];
            header_shift_next    = '0;
            byte_index_next      = '0;
            consumed_count_next  = cur_consumed + id3w_pkg::FRAME_HDR_LEN +
                                   {4'd0, cur_frame_len};
            payload_left_next    = cur_frame_len;
            // empty frame: next byte opens the next frame header
            phase_next = (cur_frame_len != 28'd0) ? id3w_pkg::PH_PAYLOAD
                                                  : id3w_pkg::PH_FHDR;
          end else begin
            byte_index_next = cur_index + 4'd1;
          end
        end
      end
      id3w_pkg::PH_PAYLOAD: begin
        payload_left_next = left_dec;
        if (left_dec == 28'd0) begin
          phase_next      = id3w_pkg::PH_FHDR;
          byte_index_next = '0;
        end
      end
      default: begin
        // tag done or bad magic: hold until a start mark
      end
    endcase
  end

  // Result of the current byte
  always_comb begin
    pbyte = '0;
    last  = 1'b0;
    unique case (cur_phase)
      id3w_pkg::PH_TAG: begin
        if (magic_bad) begin
          ev = id3w_pkg::EV_BAD_MAGIC;
        end else if (hdr_last) begin
          ev = id3w_pkg::EV_TAG_HDR;
        end else begin
          ev = id3w_pkg::EV_HDR_BYTE;
        end
      end
      id3w_pkg::PH_FHDR: begin
        if (tag_over) begin
          ev = id3w_pkg::EV_TAG_END;
        end else if (hdr_last) begin
          ev = id3w_pkg::EV_FRAME_HDR;
        end else begin
          ev = id3w_pkg::EV_HDR_BYTE;
        end
      end
      id3w_pkg::PH_PAYLOAD: begin
        ev    = id3w_pkg::EV_PAYLOAD;
        pbyte = b;
        last  = (cur_left <= 28'd1);
      end
      default: begin
        ev = id3w_pkg::EV_OUTSIDE;
      end
    endcase
  end

  id3w_kind_class u_kind (
    .id_word    (frame_id_reg_next),
    .frame_kind (kind_next)
  );

  // Parser state registers: advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= id3w_pkg::PH_TAG;
      byte_index      <= '0;
      header_shift    <= '0;
      tag_size_reg    <= '0;
      consumed_count  <= '0;
      frame_id_reg    <= '0;
      frame_size_reg  <= '0;
      payload_left    <= '0;
      frame_flags_reg <= '0;
      version_reg     <= '0;
      revision_reg    <= '0;
      tag_flags_reg   <= '0;
    end else if (s_accept) begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      header_shift    <= header_shift_next;
      tag_size_reg    <= tag_size_reg_next;
      consumed_count  <= consumed_count_next;
      frame_id_reg    <= frame_id_reg_next;
      frame_size_reg  <= frame_size_reg_next;
      payload_left    <= payload_left_next;
      frame_flags_reg <= frame_flags_reg_next;
      version_reg     <= version_reg_next;
      revision_reg    <= revision_reg_next;
      tag_flags_reg   <= tag_flags_reg_next;
    end
  end

  // Result valid: set on accept, clear once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload: load with each accepted byte
  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_ev          <= ev;
      out_version     <= version_reg_next;
      out_revision    <= revision_reg_next;
      out_tag_flags   <= tag_flags_reg_next;
      out_tag_size    <= tag_size_reg_next;
      out_frame_id    <= frame_id_reg_next;
      out_frame_kind  <= kind_next;
      out_frame_size  <= frame_size_reg_next;
      out_frame_flags <= frame_flags_reg_next;
      out_payload     <= pbyte;
      out_last        <= last;
    end
  end

  assign m_tuser = out_ev;
  assign m_tlast = out_last;
  assign m_tdata = {7'd0, out_payload, out_frame_flags, out_frame_size, out_frame_kind,
                    out_frame_id, out_tag_size, out_tag_flags, out_revision, out_version};

`ifndef SYNTHESIS
  // A last marker only ever rides on a payload byte
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == id3w_pkg::EV_PAYLOAD))
    else $error("last marker on a non-payload result");

  // Payload phase always has bytes left to pass
  assert property (@(posedge clk) disable iff (rst)
    (phase == id3w_pkg::PH_PAYLOAD) |-> (payload_left != 28'd0))
    else $error("payload phase with no bytes left");

  // Header byte counter stays within the ten-byte header
  assert property (@(posedge clk) disable iff (rst)
    byte_index <= id3w_pkg::HDR_LAST_IDX)
    else $error("header byte index out of range");

  // A start byte that is not the magic gives bad magic next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tuser && (s_tdata != id3w_pkg::MAGIC0)) |=>
      (m_tvalid && (m_tuser == id3w_pkg::EV_BAD_MAGIC)))
    else $error("bad magic not reported");

  // A byte taken while in the done phase reports outside-tag
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && !s_tuser && (phase == id3w_pkg::PH_DONE)) |=>
      (m_tuser == id3w_pkg::EV_OUTSIDE))
    else $error("byte after tag end not reported as outside");
`endif

endmodule
